// ===== sv/ltc_pkg.sv =====
`default_nettype none

package ltc_pkg;

   // Word length saturation and line counter width.
   localparam int MAX_TOKEN_LEN = 16;
   localparam int LINE_WIDTH    = 16;
   localparam int LEN_WIDTH     = 5;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_S       = 8'h73;
   localparam logic [7:0] CH_I       = 8'h69;
   localparam logic [7:0] CH_N       = 8'h6e;
   localparam logic [7:0] CH_O       = 8'h6f;
   localparam logic [7:0] CH_A       = 8'h61;
   localparam logic [7:0] CH_L       = 8'h6c;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_LT      = 8'h3c;
   localparam logic [7:0] CH_GT      = 8'h3e;
   localparam logic [7:0] CH_EQ      = 8'h3d;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_E_UP    = 8'h45;
   localparam logic [7:0] CH_E_LOW   = 8'h65;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;

   typedef enum logic [2:0] {
      CLASS_KEYWORD    = 3'd0,
      CLASS_OPERATOR   = 3'd1,
      CLASS_IDENTIFIER = 3'd2,
      CLASS_INTEGER    = 3'd3,
      CLASS_FLOAT      = 3'd4,
      CLASS_ERROR      = 3'd5
   } token_class_type;

   typedef enum logic [1:0] {
      KWID_NONE  = 2'd0,
      KWID_SI    = 2'd1,
      KWID_SINON = 2'd2,
      KWID_ALORS = 2'd3
   } keyword_id_type;

   typedef enum logic [11:0] {
      KW_IDLE  = 12'b0000_0000_0001,
      KW_S     = 12'b0000_0000_0010,
      KW_SI    = 12'b0000_0000_0100,
      KW_SIN   = 12'b0000_0000_1000,
      KW_SINO  = 12'b0000_0001_0000,
      KW_SINON = 12'b0000_0010_0000,
      KW_A     = 12'b0000_0100_0000,
      KW_AL    = 12'b0000_1000_0000,
      KW_ALO   = 12'b0001_0000_0000,
      KW_ALOR  = 12'b0010_0000_0000,
      KW_ALORS = 12'b0100_0000_0000,
      KW_DEAD  = 12'b1000_0000_0000
   } kw_state_type;

   typedef enum logic [4:0] {
      OP_IDLE = 5'b00001,
      OP_LT   = 5'b00010,
      OP_GT   = 5'b00100,
      OP_DONE = 5'b01000,
      OP_DEAD = 5'b10000
   } op_state_type;

   typedef enum logic [7:0] {
      NUM_IDLE = 8'b0000_0001,
      NUM_INT  = 8'b0000_0010,
      NUM_DOT  = 8'b0000_0100,
      NUM_FRAC = 8'b0000_1000,
      NUM_EXP  = 8'b0001_0000,
      NUM_SIGN = 8'b0010_0000,
      NUM_EXPD = 8'b0100_0000,
      NUM_DEAD = 8'b1000_0000
   } num_state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
   } req_data_type;

   typedef struct packed {
      token_class_type        token_class;
      keyword_id_type         keyword_id;
      logic [LEN_WIDTH-1:0]   token_length;
      logic                   too_long;
      logic [LINE_WIDTH-1:0]  line_number;
   } rsp_data_type;

endpackage

`default_nettype wire

// ===== sv/lexical_token_classifier.sv =====
// Classifies a character stream, one character per beat, into delimiter-separated words
// (space, tab, newline, or a beat with at_end set). Keyword, operator, identifier and
// number recognizers run side by side in a single pass, and a non-empty word yields one
// result beat in the cycle after its delimiter is taken, carrying class, keyword, length
// (saturating at MAX_TOKEN_LEN, with too_long set beyond it) and the line it ended on.
// The only storage is the per-word recognizer state, the line counter and one output
// register, so a new character is taken in every cycle except while a result beat is
// held by rsp_stall, when req_stall is raised for any character. at_end returns the
// line count to one.
`default_nettype none

module lexical_token_classifier
   import ltc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_data_type rsp_data
);

   localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
   localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);
   localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = LEN_WIDTH'(MAX_TOKEN_LEN);

   kw_state_type          kw_ff, kw_in;
   op_state_type          op_ff, op_in;
   num_state_type         num_ff, num_in;
   logic                  ident_ff, ident_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;
   logic                  ovf_ff, ovf_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            is_delim;
   logic            is_letter;
   logic            is_digit;
   logic            is_exp;
   logic            emit;
   logic [7:0]      c;
   token_class_type cls;
   keyword_id_type  kid;

   assign c         = req_data.ch;
   assign is_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   assign is_digit  = (c >= 8'h30 && c <= 8'h39);
   assign is_exp    = (c == CH_E_UP) || (c == CH_E_LOW);
   assign is_delim  = req_data.at_end || c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;

   // Take a beat unless the held result cannot leave this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign emit      = accept && is_delim && (len_ff != '0);

   always_comb begin
      unique case (kw_ff)
         KW_IDLE:  kw_in = (c == CH_S) ? KW_S : ((c == CH_A) ? KW_A : KW_DEAD);
         KW_S:     kw_in = (c == CH_I) ? KW_SI : KW_DEAD;
         KW_SI:    kw_in = (c == CH_N) ? KW_SIN : KW_DEAD;
         KW_SIN:   kw_in = (c == CH_O) ? KW_SINO : KW_DEAD;
         KW_SINO:  kw_in = (c == CH_N) ? KW_SINON : KW_DEAD;
         KW_A:     kw_in = (c == CH_L) ? KW_AL : KW_DEAD;
         KW_AL:    kw_in = (c == CH_O) ? KW_ALO : KW_DEAD;
         KW_ALO:   kw_in = (c == CH_R) ? KW_ALOR : KW_DEAD;
         KW_ALOR:  kw_in = (c == CH_S) ? KW_ALORS : KW_DEAD;
         default:  kw_in = KW_DEAD;
      endcase

      unique case (op_ff)
         OP_IDLE: op_in = (c == CH_LT) ? OP_LT :
                          ((c == CH_GT) ? OP_GT : ((c == CH_EQ) ? OP_DONE : OP_DEAD));
         OP_LT:   op_in = (c == CH_GT || c == CH_EQ) ? OP_DONE : OP_DEAD;
         OP_GT:   op_in = (c == CH_EQ) ? OP_DONE : OP_DEAD;
         default: op_in = OP_DEAD;
      endcase

      unique case (num_ff)
         NUM_IDLE: num_in = is_digit ? NUM_INT : NUM_DEAD;
         NUM_INT:  num_in = is_digit ? NUM_INT :
                            ((c == CH_DOT) ? NUM_DOT : (is_exp ? NUM_EXP : NUM_DEAD));
         NUM_DOT:  num_in = is_digit ? NUM_FRAC : NUM_DEAD;
         NUM_FRAC: num_in = is_digit ? NUM_FRAC : (is_exp ? NUM_EXP : NUM_DEAD);
         NUM_EXP:  num_in = is_digit ? NUM_EXPD :
                            ((c == CH_PLUS || c == CH_MINUS) ? NUM_SIGN : NUM_DEAD);
         NUM_SIGN: num_in = is_digit ? NUM_EXPD : NUM_DEAD;
         NUM_EXPD: num_in = is_digit ? NUM_EXPD : NUM_DEAD;
         default:  num_in = NUM_DEAD;
      endcase

      ident_in = ident_ff && ((len_ff == '0) ? is_letter : (is_letter || is_digit));

      if (len_ff < LEN_MAX) begin
         len_in = len_ff + LEN_WIDTH'(1);
         ovf_in = ovf_ff;
      end else begin
         len_in = len_ff;
         ovf_in = 1'b1;
      end

      // Delimiter: drop the word and move the line counter.
      line_in = line_ff;
      if (is_delim) begin
         kw_in    = KW_IDLE;
         op_in    = OP_IDLE;
         num_in   = NUM_IDLE;
         ident_in = 1'b1;
         len_in   = '0;
         ovf_in   = 1'b0;
         if (req_data.at_end) begin
            line_in = LINE_ONE;
         end else if (c == CH_NEWLINE && line_ff != LINE_MAX) begin
            line_in = line_ff + LINE_ONE;
         end
      end
   end

   always_comb begin
      kid = KWID_NONE;
      priority if (kw_ff == KW_SI) begin
         cls = CLASS_KEYWORD;
         kid = KWID_SI;
      end else if (kw_ff == KW_SINON) begin
         cls = CLASS_KEYWORD;
         kid = KWID_SINON;
      end else if (kw_ff == KW_ALORS) begin
         cls = CLASS_KEYWORD;
         kid = KWID_ALORS;
      end else if (op_ff == OP_LT || op_ff == OP_GT || op_ff == OP_DONE) begin
         cls = CLASS_OPERATOR;
      end else if (ident_ff) begin
         cls = CLASS_IDENTIFIER;
      end else if (num_ff == NUM_INT) begin
         cls = CLASS_INTEGER;
      end else if (num_ff == NUM_FRAC || num_ff == NUM_EXPD) begin
         cls = CLASS_FLOAT;
      end else begin
         cls = CLASS_ERROR;
      end

      rsp_data_in.token_class  = cls;
      rsp_data_in.keyword_id   = kid;
      rsp_data_in.token_length = len_ff;
      rsp_data_in.too_long     = ovf_ff;
      rsp_data_in.line_number  = line_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff        <= KW_IDLE;
         op_ff        <= OP_IDLE;
         num_ff       <= NUM_IDLE;
         ident_ff     <= 1'b1;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         line_ff      <= LINE_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            kw_ff    <= kw_in;
            op_ff    <= op_in;
            num_ff   <= num_in;
            ident_ff <= ident_in;
            len_ff   <= len_in;
            ovf_ff   <= ovf_in;
            line_ff  <= line_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.token_length != '0)
      else $error("result beat with empty word");

   a_too_long_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.too_long |-> rsp_data_ff.token_length == LEN_MAX)
      else $error("too_long without saturated length");

   a_kwid_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.token_class == CLASS_KEYWORD) ==
                        (rsp_data_ff.keyword_id != KWID_NONE)))
      else $error("keyword id disagrees with class");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

   a_end_resets_line: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.at_end |=> line_ff == LINE_ONE)
      else $error("line counter not restarted after end of text");

endmodule

`default_nettype wire
